/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OPTB_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OPTB_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/optb_pkg.sv */
// types and constants of the output pattern timer bank
package optb_pkg;

  localparam int CHANNELS   = 16;
  localparam int TIME_WIDTH = 48;
  localparam int CIW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW         = $clog2(CHANNELS + 1);
  localparam int TCW        = $clog2(TIME_WIDTH);
  localparam int SPW        = 10;
  localparam int PW         = 31;

  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_ON    = 3'd2,
    CMD_OFF   = 3'd3,
    CMD_BLINK = 3'd4,
    CMD_IDENT = 3'd5,
    CMD_AUTO  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOCFG   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_OUT_MASK   = 3'd0,
    REG_INV_MASK   = 3'd1,
    REG_SCAN       = 3'd2,
    REG_HOLD       = 3'd3,
    REG_REPORT     = 3'd4,
    REG_IDENT_STEP = 3'd5
  } reg_e;

  typedef struct packed {
    logic [4:0] channel;
    logic       level;
    logic       pin_level;
    logic       drove;
    logic       report;
    status_e    status;
    logic       last;
  } res_t;

  localparam logic [SPW-1:0] SCAN_RST  = 10'd50;
  localparam logic [31:0]    HOLD_RST  = 32'd300000;
  localparam logic [31:0]    REP_RST   = 32'd30000;
  localparam logic [31:0]    STEP_RST  = 32'd3000;
  localparam logic [PW-1:0]  BLINK_DEF = 31'd1000;
  localparam logic [PW-1:0]  BLINK_MIN = 31'd100;

endpackage

/* hdl/optb_if.sv */
// channel interfaces of the output pattern timer bank
interface optb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [4:0] channel;
  logic       value;
  logic [30:0] duration_ms;
  logic [30:0] blink_per_ms;
  modport source (output valid, cmd, channel, value, duration_ms, blink_per_ms, input ready);
  modport sink (input valid, cmd, channel, value, duration_ms, blink_per_ms, output ready);
endinterface

interface optb_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_channel;
  logic       level;
  logic       pin_level;
  logic       drove;
  logic       report;
  logic [1:0] status;
  logic       last;
  modport source (output valid, out_channel, level, pin_level, drove, report, status, last,
                  input ready);
  modport sink (input valid, out_channel, level, pin_level, drove, report, status, last,
                output ready);
endinterface

interface optb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/optb_alu.sv */
// shared time adder and comparator
module optb_alu (
  input  optb_pkg::time_t a,
  input  optb_pkg::time_t b,
  output optb_pkg::time_t sum,
  output logic            ge
);
  import optb_pkg::*;

  assign sum = a + b;
  assign ge  = (a >= b);
endmodule

/* hdl/optb_rem.sv */
// scan phase counter with bit-serial remainder recompute
module optb_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      tick,
  input  logic                      wrap,
  input  logic [optb_pkg::SPW-1:0]  sp,
  input  optb_pkg::time_t           now,
  output logic                      busy,
  output logic                      at_period
);
  import optb_pkg::*;

  logic [SPW-1:0] rem_r, rem_nxt, sp_eff;
  logic           busy_r, busy_nxt;
  logic [TCW-1:0] cnt_r, cnt_nxt;
  logic [SPW:0]   acc, sp_x;

  assign sp_eff    = (sp == '0) ? SPW'(1) : sp;
  assign sp_x      = {1'b0, sp_eff};
  assign at_period = ((rem_r + SPW'(1)) == sp_eff);
  assign acc       = {rem_r, now[cnt_r]};
  assign busy      = busy_r;

  always_comb begin
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      rem_nxt  = '0;
      cnt_nxt  = TCW'(TIME_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (acc >= sp_x) ? SPW'(acc - sp_x) : SPW'(acc);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - TCW'(1);
      end
    end else if (tick) begin
      rem_nxt = (wrap || at_period) ? '0 : rem_r + SPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      rem_r  <= rem_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end
endmodule

/* hdl/output_pattern_timer_bank_unit.sv */
// top level of the output pattern timer bank
// Usage:
// in_ch carries one command per transfer: tick, write, on, off, blink, identify or
// auto write. cfg_ch writes the six setup registers and is always ready; a write
// of the scan period restarts a bit-serial remainder recompute of the clock,
// during which in_ch is not ready.
// out_ch carries result records; last marks the final one of a command. A tick
// that drives nothing gives no record.
// A scanning tick walks every channel with the shared adder/comparator, after
// any pending identify work.
// in_ch stays low from a transfer until its last record has been handed to the
// output register.
// One result record is buffered in a holding stage and one in the output
// register; when the receiver stalls the sequencer waits and nothing is lost.
// Reset restores register defaults, the clock to zero and all channels to off
// with the next report at the default report period.
`include "assert_macros.svh"

module output_pattern_timer_bank_unit (
  input logic         clk,
  input logic         rst_n,
  optb_in_if.sink     in_ch,
  optb_out_if.source  out_ch,
  optb_cfg_if.sink    cfg_ch
);
  import optb_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'h0001,
    S_CMD     = 14'h0002,
    S_FLIPSET = 14'h0004,
    S_EXPSET  = 14'h0008,
    S_DRV     = 14'h0010,
    S_IDCHK   = 14'h0020,
    S_IDSKIP  = 14'h0040,
    S_IDOFF   = 14'h0080,
    S_IDON    = 14'h0100,
    S_SEXP    = 14'h0200,
    S_SFLIP   = 14'h0400,
    S_SFLIPW  = 14'h0800,
    S_SREP    = 14'h1000,
    S_FIN     = 14'h2000
  } state_t;

  typedef enum logic [1:0] {
    RET_FIN  = 2'd0,
    RET_NEXT = 2'd1,
    RET_SCAN = 2'd2
  } ret_t;

  function automatic logic cfgd(input logic [31:0] mask, input logic [4:0] c);
    return (c < 5'(CHANNELS)) && mask[c];
  endfunction

  function automatic res_t mk_res(input logic [31:0] inv, input logic [4:0] c,
                                  input logic lv, input logic dr, input logic rp,
                                  input status_e st);
    res_t r;
    r.channel   = c;
    r.level     = lv;
    r.pin_level = lv ^ inv[c];
    r.drove     = dr;
    r.report    = rp;
    r.status    = st;
    r.last      = 1'b0;
    return r;
  endfunction

  // configuration
  logic [31:0]    out_mask_r, out_mask_nxt, inv_mask_r, inv_mask_nxt;
  logic [SPW-1:0] scan_r, scan_nxt;
  logic [31:0]    hold_ms_r, hold_ms_nxt, rp_r, rp_nxt, step_r, step_nxt;

  // timer state
  state_t          state_r, state_nxt;
  time_t           now_r, now_nxt;
  logic            lvl_r [CHANNELS];
  logic            lvl_nxt [CHANNELS];
  logic            blk_r [CHANNELS];
  logic            blk_nxt [CHANNELS];
  logic [PW-1:0]   half_r [CHANNELS];
  logic [PW-1:0]   half_nxt [CHANNELS];
  time_t           exp_r [CHANNELS];
  time_t           exp_nxt [CHANNELS];
  time_t           man_r [CHANNELS];
  time_t           man_nxt [CHANNELS];
  time_t           flip_r [CHANNELS];
  time_t           flip_nxt [CHANNELS];
  time_t           rep_r [CHANNELS];
  time_t           rep_nxt [CHANNELS];
  logic            ident_act_r, ident_act_nxt;
  logic [IW-1:0]   ident_idx_r, ident_idx_nxt;
  time_t           ident_next_r, ident_next_nxt;
  logic [CIW-1:0]  ci_r, ci_nxt;

  // item and drive context
  cmd_e            cmd_r, cmd_nxt;
  logic [4:0]      ch_r, ch_nxt;
  logic            val_r, val_nxt;
  logic [PW-1:0]   dur_r, dur_nxt, per_r, per_nxt;
  logic [CIW-1:0]  tgt_r, tgt_nxt;
  logic            drv_lv_r, drv_lv_nxt, force_r, force_nxt;
  ret_t            ret_r, ret_nxt;

  // result staging
  res_t            hold_r, hold_nxt, out_r, out_nxt;
  logic            hold_v_r, hold_v_nxt, out_v_r, out_v_nxt;

  logic            in_acc, cfg_acc, out_free, can_emit, emit_en, ci_last;
  res_t            emit_rec;
  time_t           alu_b, alu_sum;
  logic            alu_ge, rem_busy, at_period, rem_tick, tick_wrap, chg;
  logic [CIW-1:0]  cidx, kidx;
  logic [PW-1:0]   blink_p;

  optb_alu u_alu (
    .a   (now_r),
    .b   (alu_b),
    .sum (alu_sum),
    .ge  (alu_ge)
  );

  optb_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_acc && (cfg_ch.index == REG_SCAN)),
    .tick      (rem_tick),
    .wrap      (tick_wrap),
    .sp        (scan_r),
    .now       (now_r),
    .busy      (rem_busy),
    .at_period (at_period)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !rem_busy;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;
  assign out_free     = !out_v_r || out_ch.ready;
  assign can_emit     = !hold_v_r || out_free;
  assign ci_last      = (ci_r == CIW'(CHANNELS - 1));
  assign cidx         = ch_r[CIW-1:0];
  assign kidx         = ident_idx_r[CIW-1:0];
  assign tick_wrap    = (alu_sum == '0);

  always_comb begin
    blink_p = (per_r == '0) ? BLINK_DEF : per_r;
    if (blink_p < BLINK_MIN) begin
      blink_p = BLINK_MIN;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_channel = out_r.channel;
  assign out_ch.level       = out_r.level;
  assign out_ch.pin_level   = out_r.pin_level;
  assign out_ch.drove       = out_r.drove;
  assign out_ch.report      = out_r.report;
  assign out_ch.status      = out_r.status;
  assign out_ch.last        = out_r.last;

  // shared unit operand select
  always_comb begin
    unique case (state_r)
      S_CMD: begin
        if (cmd_r == CMD_TICK) begin
          alu_b = TIME_WIDTH'(1);
        end else if (cmd_r == CMD_AUTO) begin
          alu_b = man_r[cidx];
        end else begin
          alu_b = TIME_WIDTH'(hold_ms_r);
        end
      end
      S_FLIPSET: alu_b = TIME_WIDTH'(half_r[tgt_r]);
      S_EXPSET:  alu_b = TIME_WIDTH'(dur_r);
      S_IDCHK:   alu_b = ident_next_r;
      S_IDON:    alu_b = TIME_WIDTH'(step_r);
      S_SEXP:    alu_b = exp_r[ci_r];
      S_SFLIP:   alu_b = flip_r[ci_r];
      S_SFLIPW:  alu_b = TIME_WIDTH'(half_r[ci_r]);
      S_SREP:    alu_b = rep_r[ci_r];
      default:   alu_b = TIME_WIDTH'(rp_r);
    endcase
  end

  assign chg = (lvl_r[tgt_r] != drv_lv_r);

  always_comb begin
    out_mask_nxt   = out_mask_r;
    inv_mask_nxt   = inv_mask_r;
    scan_nxt       = scan_r;
    hold_ms_nxt    = hold_ms_r;
    rp_nxt         = rp_r;
    step_nxt       = step_r;
    state_nxt      = state_r;
    now_nxt        = now_r;
    lvl_nxt        = lvl_r;
    blk_nxt        = blk_r;
    half_nxt       = half_r;
    exp_nxt        = exp_r;
    man_nxt        = man_r;
    flip_nxt       = flip_r;
    rep_nxt        = rep_r;
    ident_act_nxt  = ident_act_r;
    ident_idx_nxt  = ident_idx_r;
    ident_next_nxt = ident_next_r;
    ci_nxt         = ci_r;
    cmd_nxt        = cmd_r;
    ch_nxt         = ch_r;
    val_nxt        = val_r;
    dur_nxt        = dur_r;
    per_nxt        = per_r;
    tgt_nxt        = tgt_r;
    drv_lv_nxt     = drv_lv_r;
    force_nxt      = force_r;
    ret_nxt        = ret_r;
    hold_nxt       = hold_r;
    hold_v_nxt     = hold_v_r;
    out_nxt        = out_r;
    out_v_nxt      = out_v_r;
    emit_en        = 1'b0;
    emit_rec       = hold_r;
    rem_tick       = 1'b0;

    if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_OUT_MASK:   out_mask_nxt = cfg_ch.data;
        REG_INV_MASK:   inv_mask_nxt = cfg_ch.data;
        REG_SCAN:       scan_nxt     = cfg_ch.data[SPW-1:0];
        REG_HOLD:       hold_ms_nxt  = cfg_ch.data;
        REG_REPORT:     rp_nxt       = cfg_ch.data;
        REG_IDENT_STEP: step_nxt     = cfg_ch.data;
        default: ;
      endcase
    end

    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = cmd_e'(in_ch.cmd);
          ch_nxt    = in_ch.channel;
          val_nxt   = in_ch.value;
          dur_nxt   = in_ch.duration_ms;
          per_nxt   = in_ch.blink_per_ms;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (can_emit) begin
          if (cmd_r == CMD_TICK) begin
            now_nxt  = alu_sum;
            rem_tick = 1'b1;
            if (tick_wrap || at_period) begin
              ci_nxt    = '0;
              state_nxt = ident_act_r ? S_IDCHK : S_SEXP;
            end else begin
              state_nxt = S_FIN;
            end
          end else if (cmd_r == CMD_IDENT) begin
            ident_act_nxt  = 1'b1;
            ident_idx_nxt  = '0;
            ident_next_nxt = '0;
            emit_en        = 1'b1;
            emit_rec       = mk_res(inv_mask_r, 5'd0, 1'b0, 1'b0, 1'b0, ST_OK);
            state_nxt      = S_FIN;
          end else if (!cfgd(out_mask_r, ch_r)) begin
            emit_en   = 1'b1;
            emit_rec  = mk_res(inv_mask_r, ch_r, 1'b0, 1'b0, 1'b0, ST_NOCFG);
            state_nxt = S_FIN;
          end else if (cmd_r == CMD_AUTO) begin
            if (!alu_ge || blk_r[cidx] || (exp_r[cidx] != '0)) begin
              emit_en   = 1'b1;
              emit_rec  = mk_res(inv_mask_r, ch_r, lvl_r[cidx], 1'b0, 1'b0, ST_OK);
              state_nxt = S_FIN;
            end else begin
              tgt_nxt    = cidx;
              drv_lv_nxt = val_r;
              force_nxt  = 1'b0;
              ret_nxt    = RET_FIN;
              state_nxt  = S_DRV;
            end
          end else begin
            man_nxt[cidx] = alu_sum;
            tgt_nxt       = cidx;
            unique case (cmd_r)
              CMD_WRITE, CMD_ON, CMD_OFF: begin
                drv_lv_nxt     = (cmd_r == CMD_WRITE) ? val_r : (cmd_r == CMD_ON);
                blk_nxt[cidx]  = 1'b0;
                half_nxt[cidx] = '0;
                state_nxt      = S_EXPSET;
              end
              CMD_BLINK: begin
                drv_lv_nxt     = 1'b1;
                blk_nxt[cidx]  = 1'b1;
                half_nxt[cidx] = blink_p >> 1;
                state_nxt      = S_FLIPSET;
              end
              default: begin
                emit_en   = 1'b1;
                emit_rec  = mk_res(inv_mask_r, ch_r, lvl_r[cidx], 1'b0, 1'b0, ST_UNKNOWN);
                state_nxt = S_FIN;
              end
            endcase
          end
        end
      end
      S_FLIPSET: begin
        if (can_emit) begin
          flip_nxt[tgt_r] = alu_sum;
          state_nxt       = S_EXPSET;
        end
      end
      S_EXPSET: begin
        if (can_emit) begin
          exp_nxt[tgt_r] = (drv_lv_r && (dur_r != '0)) ? alu_sum : '0;
          force_nxt      = 1'b1;
          ret_nxt        = RET_FIN;
          state_nxt      = S_DRV;
        end
      end
      S_DRV: begin
        if (can_emit) begin
          lvl_nxt[tgt_r] = drv_lv_r;
          if (chg || force_r) begin
            rep_nxt[tgt_r] = alu_sum;
          end
          emit_en  = 1'b1;
          emit_rec = mk_res(inv_mask_r, 5'(tgt_r), drv_lv_r, 1'b1, chg || force_r, ST_OK);
          unique case (ret_r)
            RET_FIN: state_nxt = S_FIN;
            RET_SCAN: begin
              ci_nxt    = '0;
              state_nxt = S_SEXP;
            end
            default: begin
              ci_nxt    = ci_r + CIW'(1);
              state_nxt = ci_last ? S_FIN : S_SEXP;
            end
          endcase
        end
      end
      S_IDCHK: begin
        if (can_emit) begin
          ci_nxt    = '0;
          state_nxt = alu_ge ? S_IDSKIP : S_SEXP;
        end
      end
      S_IDSKIP: begin
        if (can_emit) begin
          if ((ident_idx_r < IW'(CHANNELS)) && !cfgd(out_mask_r, 5'(ident_idx_r))) begin
            ident_idx_nxt = ident_idx_r + IW'(1);
          end else begin
            ci_nxt    = '0;
            state_nxt = S_IDOFF;
          end
        end
      end
      S_IDOFF: begin
        if (can_emit) begin
          if (cfgd(out_mask_r, 5'(ci_r)) && lvl_r[ci_r]) begin
            lvl_nxt[ci_r] = 1'b0;
            rep_nxt[ci_r] = alu_sum;
            emit_en       = 1'b1;
            emit_rec      = mk_res(inv_mask_r, 5'(ci_r), 1'b0, 1'b1, 1'b1, ST_OK);
          end
          ci_nxt    = ci_r + CIW'(1);
          state_nxt = ci_last ? S_IDON : S_IDOFF;
        end
      end
      S_IDON: begin
        if (can_emit) begin
          if (ident_idx_r >= IW'(CHANNELS)) begin
            ident_act_nxt = 1'b0;
            ci_nxt        = '0;
            state_nxt     = S_SEXP;
          end else begin
            blk_nxt[kidx]  = 1'b0;
            exp_nxt[kidx]  = '0;
            man_nxt[kidx]  = alu_sum;
            ident_next_nxt = alu_sum;
            ident_idx_nxt  = ident_idx_r + IW'(1);
            tgt_nxt        = kidx;
            drv_lv_nxt     = 1'b1;
            force_nxt      = 1'b1;
            ret_nxt        = RET_SCAN;
            state_nxt      = S_DRV;
          end
        end
      end
      S_SEXP: begin
        if (can_emit) begin
          if (!cfgd(out_mask_r, 5'(ci_r))) begin
            ci_nxt    = ci_r + CIW'(1);
            state_nxt = ci_last ? S_FIN : S_SEXP;
          end else if ((exp_r[ci_r] != '0) && alu_ge) begin
            blk_nxt[ci_r] = 1'b0;
            exp_nxt[ci_r] = '0;
            tgt_nxt       = ci_r;
            drv_lv_nxt    = 1'b0;
            force_nxt     = 1'b1;
            ret_nxt       = RET_NEXT;
            state_nxt     = S_DRV;
          end else begin
            state_nxt = blk_r[ci_r] ? S_SFLIP : S_SREP;
          end
        end
      end
      S_SFLIP: begin
        if (can_emit) begin
          state_nxt = alu_ge ? S_SFLIPW : S_SREP;
        end
      end
      S_SFLIPW: begin
        if (can_emit) begin
          flip_nxt[ci_r] = alu_sum;
          lvl_nxt[ci_r]  = !lvl_r[ci_r];
          emit_en        = 1'b1;
          emit_rec       = mk_res(inv_mask_r, 5'(ci_r), !lvl_r[ci_r], 1'b1, 1'b0, ST_OK);
          ci_nxt         = ci_r + CIW'(1);
          state_nxt      = ci_last ? S_FIN : S_SEXP;
        end
      end
      S_SREP: begin
        if (can_emit) begin
          if (alu_ge) begin
            tgt_nxt    = ci_r;
            drv_lv_nxt = lvl_r[ci_r];
            force_nxt  = 1'b1;
            ret_nxt    = RET_NEXT;
            state_nxt  = S_DRV;
          end else begin
            ci_nxt    = ci_r + CIW'(1);
            state_nxt = ci_last ? S_FIN : S_SEXP;
          end
        end
      end
      S_FIN: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a new record pushes the held one out
    if (emit_en) begin
      if (hold_v_r) begin
        out_nxt   = hold_r;
        out_v_nxt = 1'b1;
      end
      hold_nxt   = emit_rec;
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_mask_r   <= '0;
      inv_mask_r   <= '0;
      scan_r       <= SCAN_RST;
      hold_ms_r    <= HOLD_RST;
      rp_r         <= REP_RST;
      step_r       <= STEP_RST;
      state_r      <= S_IDLE;
      now_r        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        lvl_r[i]  <= 1'b0;
        blk_r[i]  <= 1'b0;
        half_r[i] <= '0;
        exp_r[i]  <= '0;
        man_r[i]  <= '0;
        flip_r[i] <= '0;
        rep_r[i]  <= TIME_WIDTH'(REP_RST);
      end
      ident_act_r  <= 1'b0;
      ident_idx_r  <= '0;
      ident_next_r <= '0;
      ci_r         <= '0;
      hold_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      out_mask_r   <= out_mask_nxt;
      inv_mask_r   <= inv_mask_nxt;
      scan_r       <= scan_nxt;
      hold_ms_r    <= hold_ms_nxt;
      rp_r         <= rp_nxt;
      step_r       <= step_nxt;
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      lvl_r        <= lvl_nxt;
      blk_r        <= blk_nxt;
      half_r       <= half_nxt;
      exp_r        <= exp_nxt;
      man_r        <= man_nxt;
      flip_r       <= flip_nxt;
      rep_r        <= rep_nxt;
      ident_act_r  <= ident_act_nxt;
      ident_idx_r  <= ident_idx_nxt;
      ident_next_r <= ident_next_nxt;
      ci_r         <= ci_nxt;
      hold_v_r     <= hold_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    ch_r     <= ch_nxt;
    val_r    <= val_nxt;
    dur_r    <= dur_nxt;
    per_r    <= per_nxt;
    tgt_r    <= tgt_nxt;
    drv_lv_r <= drv_lv_nxt;
    force_r  <= force_nxt;
    ret_r    <= ret_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
  end

  `OPTB_ASSERT_IMP(a_ready_no_hold, clk, rst_n, in_ch.ready, !hold_v_r,
                   "ready while a result is still held")
  `OPTB_ASSERT_NXT(a_accept_to_cmd, clk, rst_n, in_acc, state_r == S_CMD,
                   "accepted item did not start decoding")
  `OPTB_ASSERT_IMP(a_ident_idx_range, clk, rst_n, 1'b1, ident_idx_r <= IW'(CHANNELS),
                   "identify index out of range")
endmodule
